[rtl/pdlb_pkg.sv]
// pdlb_pkg: shared types, constants and sizes for the prefill/decode load balancer.
// Depends on nothing; every rtl file imports it.
`default_nettype none
package pdlb_pkg;

  // Pool and queue sizes
  localparam int PREFILL_PEERS = 32;
  localparam int DECODE_PEERS  = 64;
  localparam int QUEUE_DEPTH   = 256;
  localparam int PREDICT_DEPTH = 4;

  // Field widths
  localparam int CMD_W  = 3;
  localparam int TAG_W  = 16;
  localparam int LEN_W  = 32;
  localparam int TS_W   = 40;
  localparam int PEER_W = 6;
  localparam int TOK_W  = 32;
  localparam int COST_W = 48;
  localparam int ACT_W  = 16;
  localparam int COSTX_W = COST_W + 1;

  // Decode load is tokens times four plus the placed lengths
  localparam int LOAD_SHIFT = 2;
  localparam int LOAD_W     = COST_W + LOAD_SHIFT + 1;

  // Counts and indexes
  localparam int PCNT_W = $clog2(PREFILL_PEERS + 1);
  localparam int DCNT_W = $clog2(DECODE_PEERS + 1);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PIDX_W = (PREFILL_PEERS > 1) ? $clog2(PREFILL_PEERS) : 1;
  localparam int DIDX_W = (DECODE_PEERS > 1) ? $clog2(DECODE_PEERS) : 1;
  localparam int PT_W   = (PIDX_W > PEER_W) ? PIDX_W : PEER_W;
  localparam int DT_W   = (DIDX_W > PEER_W) ? DIDX_W : PEER_W;
  localparam int NLEN   = PREDICT_DEPTH + 1;
  localparam int K_W    = $clog2(NLEN);

  // Commands
  localparam logic [CMD_W-1:0] CMD_PF_ASSIGN  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PF_RELEASE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_D_ASSIGN   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_D_TOKENS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_D_RELEASE  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PF_PEERS  = 2'd0;
  localparam logic [1:0] CFG_D_PEERS   = 2'd1;
  localparam logic [1:0] CFG_D_LIMIT   = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TAG_W-1:0]  request_tag;
    logic [LEN_W-1:0]  job_length;
    logic [TS_W-1:0]   now_ms;
    logic [PEER_W-1:0] peer;
    logic [TOK_W-1:0]  token_count;
  } req_t;

  typedef struct packed {
    logic [PEER_W-1:0] chosen_peer;
    logic              queue_accepted;
    logic              tag_found;
  } rsp_t;

  // Queue entry and control
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [LEN_W-1:0] len;
    logic [TS_W-1:0]  ts;
  } qent_t;

  typedef struct packed {
    logic              insert;
    logic [QCNT_W-1:0] count;
    logic [TAG_W-1:0]  tag;
    logic [LEN_W-1:0]  len;
    logic [TS_W-1:0]   now;
  } qctl_t;

  typedef struct packed {
    logic valid;
    logic found;
  } qtok_t;

  // Prefill cells
  typedef struct packed {
    logic              add;
    logic              sub;
    logic [PT_W-1:0]   target;
    logic [LEN_W-1:0]  amount;
  } pop_t;

  typedef struct packed {
    logic              valid;
    logic              have;
    logic [PT_W-1:0]   idx;
    logic [COST_W-1:0] cost;
  } pscan_t;

  // Decode cells
  typedef enum logic [2:0] {
    DOP_NONE    = 3'd0,
    DOP_TOKENS  = 3'd1,
    DOP_RELEASE = 3'd2,
    DOP_INIT    = 3'd3,
    DOP_ADD     = 3'd4,
    DOP_BUMP    = 3'd5
  } dop_code_t;

  typedef struct packed {
    dop_code_t         code;
    logic [DT_W-1:0]   target;
    logic [TOK_W-1:0]  amount;
  } dop_t;

  typedef struct packed {
    logic              valid;
    logic              ok;
    logic [DT_W-1:0]   pick;
    logic [LOAD_W-1:0] pick_load;
    logic [DT_W-1:0]   any;
    logic [LOAD_W-1:0] any_load;
  } dscan_t;

endpackage
`default_nettype wire

[rtl/pdlb_qcell.sv]
// pdlb_qcell: one slot of the time-ordered prefill queue.
// Depends on pdlb_pkg; shifts right on insert, left during a removal sweep.
`default_nettype none
module pdlb_qcell import pdlb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [QCNT_W-1:0] index,
  input  qctl_t             ctl,
  input  qent_t             left,
  input  logic              left_gt,
  input  qent_t             right,
  input  qtok_t             rm_in,
  output qent_t             ent,
  output logic              gt,
  output qtok_t             rm_out
);

  logic in_range;
  logic match;

  always_comb begin
    in_range = index < ctl.count;
    gt       = in_range && (ent.ts > ctl.now);
    match    = rm_in.found || (in_range && (ent.tag == ctl.tag));
  end

  // Payload: no reset
  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (left_gt) begin
        ent <= left;
      end else if ((index <= ctl.count) && (!in_range || (ent.ts > ctl.now))) begin
        ent <= '{tag: ctl.tag, len: ctl.len, ts: ctl.now};
      end
    end else if (rm_in.valid && match) begin
      ent <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rm_out <= '0;
    end else begin
      rm_out.valid <= rm_in.valid;
      rm_out.found <= rm_in.valid && match;
    end
  end

endmodule
`default_nettype wire

[rtl/pdlb_pcell.sv]
// pdlb_pcell: one prefill server's accumulated cost and its stage of the min scan.
// Depends on pdlb_pkg.
`default_nettype none
module pdlb_pcell import pdlb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [PT_W-1:0]   index,
  input  logic [PCNT_W-1:0] count,
  input  pop_t              op,
  input  pscan_t            scan_in,
  output pscan_t            scan_out
);

  logic [COST_W-1:0]  cost;
  logic [COST_W-1:0]  amt;
  logic [COSTX_W-1:0] sum;
  logic               hit;
  pscan_t             scan_next;

  always_comb begin
    amt       = COST_W'(op.amount);
    hit       = op.target == index;
    sum       = {1'b0, cost} + {1'b0, amt};
    scan_next = scan_in;
    // Strictly smaller wins, so the lowest index keeps ties
    if (scan_in.valid && (index < count) && (!scan_in.have || (cost < scan_in.cost))) begin
      scan_next.have = 1'b1;
      scan_next.idx  = index;
      scan_next.cost = cost;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cost     <= '0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
      if (op.add && hit) begin
        cost <= sum[COST_W] ? '1 : sum[COST_W-1:0];
      end else if (op.sub && hit) begin
        cost <= (cost > amt) ? cost - amt : '0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/pdlb_dcell.sv]
// pdlb_dcell: one decode server's token total, active count and trial load.
// Depends on pdlb_pkg; holds one stage of the least-load scan.
`default_nettype none
module pdlb_dcell import pdlb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [DT_W-1:0]   index,
  input  logic [DCNT_W-1:0] count,
  input  logic [ACT_W-1:0]  limit,
  input  dop_t              op,
  input  dscan_t            scan_in,
  output dscan_t            scan_out
);

  logic [COST_W-1:0]  tokens;
  logic [ACT_W-1:0]   active;
  logic [LOAD_W-1:0]  load;
  logic [COST_W-1:0]  amt;
  logic [COSTX_W-1:0] sum;
  logic               hit;
  logic               in_range;
  dscan_t             scan_next;

  always_comb begin
    amt       = COST_W'(op.amount);
    hit       = op.target == index;
    sum       = {1'b0, tokens} + {1'b0, amt};
    in_range  = index < count;
    scan_next = scan_in;
    if (scan_in.valid && in_range) begin
      if ((active <= limit) && (!scan_in.ok || (load < scan_in.pick_load))) begin
        scan_next.ok        = 1'b1;
        scan_next.pick      = index;
        scan_next.pick_load = load;
      end
      // Server zero seeds the fallback choice
      if ((index == '0) || (load < scan_in.any_load)) begin
        scan_next.any      = index;
        scan_next.any_load = load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tokens   <= '0;
      active   <= '0;
      scan_out <= '0;
    end else begin
      scan_out <= scan_next;
      case (op.code)
        DOP_TOKENS: begin
          if (hit) tokens <= sum[COST_W] ? '1 : sum[COST_W-1:0];
        end
        DOP_RELEASE: begin
          if (hit) begin
            if (active != '0) active <= active - 1'b1;
            tokens <= (tokens > amt) ? tokens - amt : '0;
          end
        end
        DOP_BUMP: begin
          if (hit && (active != '1)) active <= active + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Trial load: payload, rebuilt from the token total at the start of each decode assign
  always_ff @(posedge clk) begin
    case (op.code)
      DOP_INIT: load <= {1'b0, tokens, {LOAD_SHIFT{1'b0}}};
      DOP_ADD:  if (hit) load <= load + LOAD_W'(op.amount);
      default:  ;
    endcase
  end

endmodule
`default_nettype wire

[rtl/prefill_decode_load_balancer.sv]
// prefill_decode_load_balancer: top level, controller and the three rows of cells.
// Depends on pdlb_pkg, pdlb_qcell, pdlb_pcell and pdlb_dcell.
//
//  channel  | handshake            | payload      | carries
//  ---------+----------------------+--------------+-------------------------------
//  req      | req_valid/req_stall  | req (req_t)  | one command item
//  rsp      | rsp_valid/rsp_stall  | rsp (rsp_t)  | one result item per command
//  cfg      | cfg_write            | cfg_index,   | peer counts and request limit
//           |                      | cfg_data     |
//
// One item at a time. Prefill assign runs a min scan through the prefill row;
// prefill release runs a removal sweep through the queue row; decode assign
// runs one scan of the decode row per placed length. Reset is synchronous and
// clears all counters; queue slots are never cleared, only the fill count.
// The next item is taken while a result waits in the output register; a stalled
// rsp holds only the finish of the following item.
`default_nettype none
module prefill_decode_load_balancer import pdlb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_PF_INS   = 12'b000000000010,
    S_PF_SCAN  = 12'b000000000100,
    S_PF_REL   = 12'b000000001000,
    S_RM       = 12'b000000010000,
    S_D_PREP   = 12'b000000100000,
    S_D_SORT   = 12'b000001000000,
    S_D_LAUNCH = 12'b000010000000,
    S_D_SCAN   = 12'b000100000000,
    S_D_BUMP   = 12'b001000000000,
    S_D_OP     = 12'b010000000000,
    S_RESP     = 12'b100000000000
  } state_t;

  state_t state;
  req_t   cur;

  // Configuration
  logic [5:0]       pf_peers;
  logic [6:0]       d_peers;
  logic [ACT_W-1:0] d_limit;
  logic [PCNT_W-1:0] pf_n;
  logic [DCNT_W-1:0] d_n;

  // Queue fill and results
  logic [QCNT_W-1:0] qcount;
  logic [PEER_W-1:0] res_chosen;
  logic              res_acc;
  logic              res_found;
  logic [DT_W-1:0]   d_chosen;

  // LPT work registers
  logic [LEN_W-1:0] lens      [NLEN];
  logic [LEN_W-1:0] lens_sort [NLEN];
  logic [K_W-1:0]   sort_pass;
  logic [K_W-1:0]   k;
  logic [K_W-1:0]   q_cnt;
  logic [DT_W-1:0]  d_pick;

  // Cell rows
  qent_t  q_ent [QUEUE_DEPTH];
  logic   q_gt  [QUEUE_DEPTH];
  qtok_t  q_rm  [QUEUE_DEPTH];
  qctl_t  qctl;
  qtok_t  rm_start;
  pscan_t p_scan [PREFILL_PEERS];
  pscan_t p_start;
  pop_t   pop;
  dscan_t d_scan [DECODE_PEERS];
  dscan_t d_start;
  dop_t   dop;

  assign req_stall = (state != S_IDLE);

  // Clamp peer counts to one at the bottom and the pool size at the top
  always_comb begin
    if (pf_peers == '0)                pf_n = PCNT_W'(1);
    else if (pf_peers > PREFILL_PEERS) pf_n = PCNT_W'(PREFILL_PEERS);
    else                               pf_n = PCNT_W'(pf_peers);
    if (d_peers == '0)                 d_n = DCNT_W'(1);
    else if (d_peers > DECODE_PEERS)   d_n = DCNT_W'(DECODE_PEERS);
    else                               d_n = DCNT_W'(d_peers);
    q_cnt  = (qcount < PREDICT_DEPTH) ? K_W'(qcount) : K_W'(PREDICT_DEPTH);
    d_pick = d_scan[DECODE_PEERS-1].ok ? d_scan[DECODE_PEERS-1].pick
                                       : d_scan[DECODE_PEERS-1].any;
  end

  // One odd-even transposition pass, descending
  always_comb begin
    for (int j = 0; j < NLEN; j++) lens_sort[j] = lens[j];
    for (int j = 0; j < NLEN - 1; j++) begin
      if ((j[0] == sort_pass[0]) && (lens[j] < lens[j+1])) begin
        lens_sort[j]   = lens[j+1];
        lens_sort[j+1] = lens[j];
      end
    end
  end

  // Commands into the rows
  always_comb begin
    qctl        = '0;
    qctl.count  = qcount;
    qctl.tag    = cur.request_tag;
    qctl.len    = cur.job_length;
    qctl.now    = cur.now_ms;
    rm_start    = '0;
    p_start     = '0;
    pop         = '0;
    d_start     = '0;
    dop         = '0;
    dop.code    = DOP_NONE;
    case (state)
      S_PF_INS: begin
        qctl.insert   = qcount < QUEUE_DEPTH;
        p_start.valid = 1'b1;
      end
      S_PF_SCAN: begin
        if (p_scan[PREFILL_PEERS-1].valid) begin
          pop.add    = 1'b1;
          pop.target = p_scan[PREFILL_PEERS-1].idx;
          pop.amount = cur.job_length;
        end
      end
      S_PF_REL: begin
        pop.sub        = 1'b1;
        pop.target     = PT_W'(cur.peer);
        pop.amount     = cur.job_length;
        rm_start.valid = 1'b1;
      end
      S_D_PREP: dop.code = DOP_INIT;
      S_D_LAUNCH: d_start.valid = 1'b1;
      S_D_SCAN: begin
        if (d_scan[DECODE_PEERS-1].valid) begin
          dop.code   = DOP_ADD;
          dop.target = d_pick;
          dop.amount = lens[k];
        end
      end
      S_D_BUMP: begin
        dop.code   = DOP_BUMP;
        dop.target = d_chosen;
      end
      S_D_OP: begin
        dop.code   = (cur.command == CMD_D_TOKENS) ? DOP_TOKENS : DOP_RELEASE;
        dop.target = DT_W'(cur.peer);
        dop.amount = cur.token_count;
      end
      default: ;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pf_peers <= 6'd32;
      d_peers  <= 7'd64;
      d_limit  <= 16'hFFFF;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PF_PEERS: pf_peers <= cfg_data[5:0];
        CFG_D_PEERS:  d_peers  <= cfg_data[6:0];
        CFG_D_LIMIT:  d_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qcount    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (req.command)
              CMD_PF_ASSIGN:  state <= S_PF_INS;
              CMD_PF_RELEASE: state <= S_PF_REL;
              CMD_D_ASSIGN:   state <= S_D_PREP;
              CMD_D_TOKENS:   state <= S_D_OP;
              CMD_D_RELEASE:  state <= S_D_OP;
              default:        state <= S_RESP;
            endcase
          end
        end
        S_PF_INS: begin
          if (qcount < QUEUE_DEPTH) qcount <= qcount + 1'b1;
          state <= S_PF_SCAN;
        end
        S_PF_SCAN: if (p_scan[PREFILL_PEERS-1].valid) state <= S_RESP;
        S_PF_REL:  state <= S_RM;
        S_RM: begin
          if (q_rm[QUEUE_DEPTH-1].valid) begin
            if (q_rm[QUEUE_DEPTH-1].found) qcount <= qcount - 1'b1;
            state <= S_RESP;
          end
        end
        S_D_PREP: state <= S_D_SORT;
        S_D_SORT: if (sort_pass == K_W'(NLEN - 1)) state <= S_D_LAUNCH;
        S_D_LAUNCH: state <= S_D_SCAN;
        S_D_SCAN: begin
          if (d_scan[DECODE_PEERS-1].valid) begin
            state <= (lens[k] == cur.job_length) ? S_D_BUMP : S_D_LAUNCH;
          end
        end
        S_D_BUMP: state <= S_RESP;
        S_D_OP:   state <= S_RESP;
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result valid: raise when a result is loaded, drop once it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_RESP) && (!rsp_valid || !rsp_stall)) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Item, result and LPT payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cur        <= req;
          res_chosen <= '0;
          res_acc    <= 1'b0;
          res_found  <= 1'b0;
        end
      end
      S_PF_INS: res_acc <= qcount < QUEUE_DEPTH;
      S_PF_SCAN: begin
        if (p_scan[PREFILL_PEERS-1].valid) begin
          res_chosen <= p_scan[PREFILL_PEERS-1].idx[PEER_W-1:0];
        end
      end
      S_RM: if (q_rm[QUEUE_DEPTH-1].valid) res_found <= q_rm[QUEUE_DEPTH-1].found;
      S_D_PREP: begin
        // Oldest queued lengths, then the own length, zero above
        for (int j = 0; j < NLEN; j++) begin
          if (K_W'(j) < q_cnt)       lens[j] <= q_ent[j].len;
          else if (K_W'(j) == q_cnt) lens[j] <= cur.job_length;
          else                       lens[j] <= '0;
        end
        sort_pass <= '0;
        k         <= '0;
      end
      S_D_SORT: begin
        for (int j = 0; j < NLEN; j++) lens[j] <= lens_sort[j];
        sort_pass <= sort_pass + 1'b1;
      end
      S_D_SCAN: begin
        if (d_scan[DECODE_PEERS-1].valid) begin
          if (lens[k] == cur.job_length) begin
            d_chosen   <= d_pick;
            res_chosen <= d_pick[PEER_W-1:0];
          end else begin
            k <= k + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp.chosen_peer    <= res_chosen;
          rsp.queue_accepted <= res_acc;
          rsp.tag_found      <= res_found;
        end
      end
      default: ;
    endcase
  end

  // Queue row
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_q
    qent_t q_left;
    logic  q_left_gt;
    qent_t q_right;
    qtok_t q_rm_in;
    if (i == 0) begin : g_first
      assign q_left    = '0;
      assign q_left_gt = 1'b0;
      assign q_rm_in   = rm_start;
    end else begin : g_mid
      assign q_left    = q_ent[i-1];
      assign q_left_gt = q_gt[i-1];
      assign q_rm_in   = q_rm[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign q_right = '0;
    end else begin : g_inner
      assign q_right = q_ent[i+1];
    end
    pdlb_qcell u_qcell (
      .clk     (clk),
      .rst     (rst),
      .index   (QCNT_W'(i)),
      .ctl     (qctl),
      .left    (q_left),
      .left_gt (q_left_gt),
      .right   (q_right),
      .rm_in   (q_rm_in),
      .ent     (q_ent[i]),
      .gt      (q_gt[i]),
      .rm_out  (q_rm[i])
    );
  end

  // Prefill row
  for (genvar i = 0; i < PREFILL_PEERS; i++) begin : g_p
    pscan_t p_in;
    if (i == 0) begin : g_first
      assign p_in = p_start;
    end else begin : g_mid
      assign p_in = p_scan[i-1];
    end
    pdlb_pcell u_pcell (
      .clk      (clk),
      .rst      (rst),
      .index    (PT_W'(i)),
      .count    (pf_n),
      .op       (pop),
      .scan_in  (p_in),
      .scan_out (p_scan[i])
    );
  end

  // Decode row
  for (genvar i = 0; i < DECODE_PEERS; i++) begin : g_d
    dscan_t d_in;
    if (i == 0) begin : g_first
      assign d_in = d_start;
    end else begin : g_mid
      assign d_in = d_scan[i-1];
    end
    pdlb_dcell u_dcell (
      .clk      (clk),
      .rst      (rst),
      .index    (DT_W'(i)),
      .count    (d_n),
      .limit    (d_limit),
      .op       (dop),
      .scan_in  (d_in),
      .scan_out (d_scan[i])
    );
  end

endmodule
`default_nettype wire
